// ----- rtl/hcb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants, codes and types of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int COUNT_BITS   = 24;
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_LIMIT   = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int NSYM         = 256;
  localparam int NPOS         = 512;
  localparam int SYM_W        = 8;
  localparam int POS_W        = 9;
  localparam int DEPTH_W      = 8;
  localparam int WORD_W       = 32;
  localparam int LEN_W        = 6;
  localparam int CODE_ENT_W   = 1 + LEN_W + WORD_W;
  localparam int WT_ENT_W     = 1 + COUNT_BITS;
  localparam int PAR_ENT_W    = 2 + POS_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [1:0] MODE_COUNT  = 2'd0;
  localparam logic [1:0] MODE_BUILD  = 2'd1;
  localparam logic [1:0] MODE_ENCODE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SATURATED = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  // Memory requests the tree builder makes on the top level's memories.
  typedef struct packed {
    logic                  ord_re;
    logic [SYM_W-1:0]      ord_addr;
    logic                  cnt_re;
    logic [SYM_W-1:0]      cnt_addr;
    logic                  code_we;
    logic [SYM_W-1:0]      code_addr;
    logic [CODE_ENT_W-1:0] code_data;
  } tree_req_t;

  typedef struct packed {
    logic done;
    logic too_long;
  } tree_stat_t;

endpackage

// ----- rtl/hcb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_in_if / hcb_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface hcb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface hcb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        present;
  logic [31:0] code_bits;
  logic [5:0]  code_length;
  modport source (output valid, output status, output present, output code_bits,
                  output code_length, input ready);
  modport sink (input valid, input status, input present, input code_bits,
                input code_length, output ready);
endinterface

// ----- rtl/hcb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/hcb_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_tree
// Tree builder: loads leaf weights, merges the two lightest live nodes by
// scanning the node list, then walks each leaf up to the root for its code.
// ----------------------------------------------------------------------------
module hcb_tree (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [hcb_pkg::POS_W-1:0]         distinct,
  input  logic [hcb_pkg::SYM_W-1:0]         ord_rdata,
  input  logic [hcb_pkg::COUNT_BITS-1:0]    cnt_rdata,
  output hcb_pkg::tree_req_t                req,
  output hcb_pkg::tree_stat_t               stat
);

  typedef enum logic [3:0] {
    T_IDLE, T_ORD, T_CNT, T_LWR, T_SCAN, T_KILL, T_MRG_A, T_MRG_B, T_MRG_N,
    T_C_ISS, T_C_CAP, T_C_WALK, T_DONE
  } tstate_t;

  localparam int CB = hcb_pkg::COUNT_BITS;
  localparam int PW = hcb_pkg::POS_W;

  tstate_t                      state_r;
  logic [PW-1:0]                p_r, end_r, alive_r, dist_r, rd_i_r, sc_pos_r;
  logic [PW-1:0]                best_pos_r, a_pos_r, n_r;
  logic                         pend_r, found_r, pass_r, long_r, done_r;
  logic [CB-1:0]                best_w_r, a_w_r;
  logic [hcb_pkg::SYM_W-1:0]    sym_r;
  logic [hcb_pkg::DEPTH_W-1:0]  d_r;
  logic [hcb_pkg::WORD_W-1:0]   word_r;

  // Node weight store, {alive, weight}, and parent store, {linked, branch, parent}.
  logic                             wt_we, wt_re, par_we, par_re;
  logic [PW-1:0]                    wt_waddr, wt_raddr, par_waddr, par_raddr;
  logic [hcb_pkg::WT_ENT_W-1:0]     wt_wdata, wt_rdata;
  logic [hcb_pkg::PAR_ENT_W-1:0]    par_wdata, par_rdata;
  logic [CB:0]                      sum;
  logic [CB-1:0]                    merged_w;
  logic                             scan_more, deep;

  hcb_ram #(.WIDTH(hcb_pkg::WT_ENT_W), .DEPTH(hcb_pkg::NPOS)) u_wt (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .re(wt_re), .raddr(wt_raddr), .rdata(wt_rdata)
  );

  hcb_ram #(.WIDTH(hcb_pkg::PAR_ENT_W), .DEPTH(hcb_pkg::NPOS)) u_par (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .re(par_re), .raddr(par_raddr), .rdata(par_rdata)
  );

  assign sum       = {1'b0, a_w_r} + {1'b0, best_w_r};
  assign merged_w  = sum[CB] ? hcb_pkg::CNT_MAX : sum[CB-1:0];
  assign scan_more = (rd_i_r < end_r);
  assign deep      = (d_r > hcb_pkg::DEPTH_W'(hcb_pkg::CODE_LIMIT));

  always_comb begin
    req       = '0;
    wt_we     = 1'b0;
    wt_waddr  = best_pos_r;
    wt_wdata  = {1'b0, best_w_r};
    wt_re     = 1'b0;
    wt_raddr  = rd_i_r;
    par_we    = 1'b0;
    par_waddr = end_r;
    par_wdata = '0;
    par_re    = 1'b0;
    par_raddr = n_r;
    case (state_r)
      T_ORD: begin
        req.ord_re   = 1'b1;
        req.ord_addr = p_r[hcb_pkg::SYM_W-1:0];
      end
      T_CNT: begin
        req.cnt_re   = 1'b1;
        req.cnt_addr = ord_rdata;
      end
      T_LWR: begin
        wt_we     = 1'b1;
        wt_waddr  = p_r;
        wt_wdata  = {1'b1, cnt_rdata};
        par_we    = 1'b1;
        par_waddr = p_r;
      end
      T_SCAN: begin
        wt_re = scan_more;
      end
      T_KILL: begin
        wt_we = 1'b1;
      end
      T_MRG_A: begin
        wt_we     = 1'b1;
        wt_waddr  = end_r;
        wt_wdata  = {1'b1, merged_w};
        par_we    = 1'b1;
        par_waddr = a_pos_r;
        par_wdata = {1'b1, 1'b0, end_r};
      end
      T_MRG_B: begin
        par_we    = 1'b1;
        par_waddr = best_pos_r;
        par_wdata = {1'b1, 1'b1, end_r};
      end
      T_MRG_N: begin
        par_we = 1'b1;
      end
      T_C_ISS: begin
        req.ord_re   = 1'b1;
        req.ord_addr = p_r[hcb_pkg::SYM_W-1:0];
      end
      T_C_CAP: begin
        par_re = 1'b1;
      end
      T_C_WALK: begin
        if (par_rdata[PW+1]) begin
          par_re    = 1'b1;
          par_raddr = par_rdata[PW-1:0];
        end else begin
          req.code_we   = 1'b1;
          req.code_addr = sym_r;
          req.code_data = {deep, d_r[hcb_pkg::LEN_W-1:0], word_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      done_r  <= 1'b0;
      long_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        T_IDLE: begin
          if (start) begin
            p_r     <= '0;
            end_r   <= distinct;
            alive_r <= distinct;
            dist_r  <= distinct;
            long_r  <= 1'b0;
            state_r <= (distinct == '0) ? T_DONE : T_ORD;
          end
        end
        T_ORD: state_r <= T_CNT;
        T_CNT: state_r <= T_LWR;
        T_LWR: begin
          p_r <= p_r + 1'b1;
          if (p_r + 1'b1 != dist_r) begin
            state_r <= T_ORD;
          end else if (alive_r > PW'(1)) begin
            rd_i_r  <= '0;
            pend_r  <= 1'b0;
            found_r <= 1'b0;
            pass_r  <= 1'b0;
            state_r <= T_SCAN;
          end else begin
            state_r <= T_DONE;
          end
        end
        T_SCAN: begin
          pend_r   <= scan_more;
          sc_pos_r <= rd_i_r;
          if (scan_more) begin
            rd_i_r <= rd_i_r + 1'b1;
          end
          // Strict less-than keeps the earliest node among equal weights.
          if (pend_r && wt_rdata[CB] && (!found_r || wt_rdata[CB-1:0] < best_w_r)) begin
            found_r    <= 1'b1;
            best_w_r   <= wt_rdata[CB-1:0];
            best_pos_r <= sc_pos_r;
          end
          if (!scan_more && !pend_r) begin
            state_r <= T_KILL;
          end
        end
        T_KILL: begin
          if (!pass_r) begin
            a_pos_r <= best_pos_r;
            a_w_r   <= best_w_r;
            pass_r  <= 1'b1;
            rd_i_r  <= '0;
            pend_r  <= 1'b0;
            found_r <= 1'b0;
            state_r <= T_SCAN;
          end else begin
            state_r <= T_MRG_A;
          end
        end
        T_MRG_A: state_r <= T_MRG_B;
        T_MRG_B: state_r <= T_MRG_N;
        T_MRG_N: begin
          end_r   <= end_r + 1'b1;
          alive_r <= alive_r - 1'b1;
          if (alive_r == PW'(2)) begin
            p_r     <= '0;
            state_r <= T_C_ISS;
          end else begin
            rd_i_r  <= '0;
            pend_r  <= 1'b0;
            found_r <= 1'b0;
            pass_r  <= 1'b0;
            state_r <= T_SCAN;
          end
        end
        T_C_ISS: begin
          n_r     <= p_r;
          d_r     <= '0;
          word_r  <= '0;
          state_r <= T_C_CAP;
        end
        T_C_CAP: begin
          sym_r   <= ord_rdata;
          state_r <= T_C_WALK;
        end
        T_C_WALK: begin
          if (par_rdata[PW+1]) begin
            if (d_r < hcb_pkg::DEPTH_W'(hcb_pkg::WORD_W)) begin
              word_r <= word_r | (hcb_pkg::WORD_W'(par_rdata[PW]) << d_r[4:0]);
            end
            d_r <= d_r + 1'b1;
            n_r <= par_rdata[PW-1:0];
          end else begin
            long_r <= long_r | deep;
            p_r    <= p_r + 1'b1;
            state_r <= (p_r + 1'b1 == dist_r) ? T_DONE : T_C_ISS;
          end
        end
        T_DONE: begin
          done_r  <= 1'b1;
          state_r <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign stat.done     = done_r;
  assign stat.too_long = long_r;

  a_merge_two_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_MRG_A |-> alive_r > PW'(1))
    else $error("merge with fewer than two live nodes");
  a_distinct_picks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_MRG_A |-> a_pos_r != best_pos_r)
    else $error("same node taken for both branches");
  a_nodes_fit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_MRG_A |-> end_r < PW'(hcb_pkg::NPOS - 1))
    else $error("node list overflow");

endmodule

// ----- rtl/huffman_code_builder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// Byte frequency counter, Huffman tree builder and code table lookup.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_if   | sink      | mode, data_byte
//  out_if  | source    | status, present, code_bits, code_length
//
// Count and encode pass through transfer, memory read and result; clear goes from transfer to result.
// Build with N symbols loads the N leaf weights, makes (N-1) merges, each scanning
// the current node list twice, then walks each leaf up to the root for its code;
// the node-list scan over the weight memory dominates the build time.
// Reset is synchronous; counts and the built flag clear at once.
// A new command is taken while the previous result waits in the output register.
module huffman_code_builder_core (
  input  logic              clk,
  input  logic              rst_n,
  hcb_in_if.sink            in_if,
  hcb_out_if.source         out_if
);

  typedef enum logic [2:0] {S_IDLE, S_COUNT, S_ENC, S_BUILD, S_DONE} state_t;

  localparam int CB = hcb_pkg::COUNT_BITS;

  state_t                         state_r;
  logic [hcb_pkg::SYM_W-1:0]      b_r;
  logic [hcb_pkg::NSYM-1:0]       cnt_vld_r;
  logic [hcb_pkg::POS_W-1:0]      distinct_r;
  logic                           built_r;
  logic [1:0]                     res_status_r, out_status_r;
  logic                           res_present_r, out_present_r, out_valid_r;
  logic [31:0]                    res_bits_r, out_bits_r;
  logic [5:0]                     res_len_r, out_len_r;

  logic                           accept, start;
  logic                           cnt_we, cnt_re, ord_we, code_re;
  logic [hcb_pkg::SYM_W-1:0]      cnt_raddr;
  logic [CB-1:0]                  cnt_rdata, cur;
  logic [hcb_pkg::SYM_W-1:0]      ord_rdata;
  logic [hcb_pkg::CODE_ENT_W-1:0] code_rdata;
  hcb_pkg::tree_req_t             treq;
  hcb_pkg::tree_stat_t            tstat;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign start       = accept && (in_if.mode == hcb_pkg::MODE_BUILD);
  assign code_re     = accept && (in_if.mode == hcb_pkg::MODE_ENCODE);
  assign cur         = cnt_vld_r[b_r] ? cnt_rdata : '0;
  assign cnt_re      = treq.cnt_re || (accept && (in_if.mode == hcb_pkg::MODE_COUNT));
  assign cnt_raddr   = (state_r == S_BUILD) ? treq.cnt_addr : in_if.data_byte;
  assign cnt_we      = (state_r == S_COUNT) && (cur != hcb_pkg::CNT_MAX);
  assign ord_we      = (state_r == S_COUNT) && (cur == '0) &&
                       (distinct_r < hcb_pkg::POS_W'(hcb_pkg::NSYM));

  hcb_ram #(.WIDTH(CB), .DEPTH(hcb_pkg::NSYM)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(b_r), .wdata(cur + 1'b1),
    .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  hcb_ram #(.WIDTH(hcb_pkg::SYM_W), .DEPTH(hcb_pkg::NSYM)) u_ord (
    .clk(clk), .we(ord_we), .waddr(distinct_r[hcb_pkg::SYM_W-1:0]), .wdata(b_r),
    .re(treq.ord_re), .raddr(treq.ord_addr), .rdata(ord_rdata)
  );

  hcb_ram #(.WIDTH(hcb_pkg::CODE_ENT_W), .DEPTH(hcb_pkg::NSYM)) u_code (
    .clk(clk), .we(treq.code_we), .waddr(treq.code_addr), .wdata(treq.code_data),
    .re(code_re), .raddr(in_if.data_byte), .rdata(code_rdata)
  );

  hcb_tree u_tree (
    .clk(clk), .rst_n(rst_n), .start(start), .distinct(distinct_r),
    .ord_rdata(ord_rdata), .cnt_rdata(cnt_rdata), .req(treq), .stat(tstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_vld_r   <= '0;
      distinct_r  <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            b_r           <= in_if.data_byte;
            res_status_r  <= hcb_pkg::ST_OK;
            res_present_r <= 1'b0;
            res_bits_r    <= '0;
            res_len_r     <= '0;
            case (in_if.mode)
              hcb_pkg::MODE_COUNT:  state_r <= S_COUNT;
              hcb_pkg::MODE_BUILD:  state_r <= S_BUILD;
              hcb_pkg::MODE_ENCODE: state_r <= S_ENC;
              hcb_pkg::MODE_CLEAR: begin
                cnt_vld_r  <= '0;
                distinct_r <= '0;
                built_r    <= 1'b0;
                state_r    <= S_DONE;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_COUNT: begin
          if (ord_we) begin
            distinct_r <= distinct_r + 1'b1;
          end
          cnt_vld_r[b_r] <= 1'b1;
          built_r        <= 1'b0;
          res_status_r   <= (cur == hcb_pkg::CNT_MAX) ? hcb_pkg::ST_SATURATED
                                                      : hcb_pkg::ST_OK;
          state_r        <= S_DONE;
        end
        S_ENC: begin
          // A byte has a code only if it was seen and the tree has two leaves.
          if (!built_r) begin
            res_status_r <= hcb_pkg::ST_NOT_BUILT;
          end else if (cnt_vld_r[b_r] && distinct_r > hcb_pkg::POS_W'(1)) begin
            res_present_r <= 1'b1;
            if (code_rdata[hcb_pkg::CODE_ENT_W-1]) begin
              res_status_r <= hcb_pkg::ST_TOO_LONG;
            end else begin
              res_bits_r <= code_rdata[hcb_pkg::WORD_W-1:0];
              res_len_r  <= code_rdata[hcb_pkg::WORD_W +: hcb_pkg::LEN_W];
            end
          end
          state_r <= S_DONE;
        end
        S_BUILD: begin
          if (tstat.done) begin
            built_r      <= 1'b1;
            res_status_r <= tstat.too_long ? hcb_pkg::ST_TOO_LONG : hcb_pkg::ST_OK;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_present_r <= res_present_r;
            out_bits_r    <= res_bits_r;
            out_len_r     <= res_len_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.present     = out_present_r;
  assign out_if.code_bits   = out_bits_r;
  assign out_if.code_length = out_len_r;

  a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r <= hcb_pkg::POS_W'(hcb_pkg::NSYM))
    else $error("distinct symbol count out of range");
  a_done_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    tstat.done |-> state_r == S_BUILD)
    else $error("tree builder finished outside a build");
  a_code_wr_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    treq.code_we |-> state_r == S_BUILD)
    else $error("code table written outside a build");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives count, build, encode and clear commands into the Huffman code
// builder and checks every result against a code table predicted in the
// bench. Traffic runs in phases of sender idling, receiver stalling, both,
// and neither, with one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [1:0]  status;
    logic        present;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
  } hcb_result_t;

  class code_table_scoreboard;
    longint      sym_cnt [hcb_pkg::NSYM];
    int          first_seen [hcb_pkg::NSYM];
    int          n_distinct;
    longint      weight [2*hcb_pkg::NSYM-1];
    int          parent [2*hcb_pkg::NSYM-1];
    int          branch [2*hcb_pkg::NSYM-1];
    int          node_list [hcb_pkg::NSYM];
    logic [31:0] word_tab [hcb_pkg::NSYM];
    int          len_tab [hcb_pkg::NSYM];
    bit          codes_ready;
    hcb_result_t pending [$];
    int          errors;

    function void clear_all();
      foreach (sym_cnt[i]) begin
        sym_cnt[i] = 0;
        len_tab[i] = 0;
        word_tab[i] = '0;
      end
      n_distinct = 0;
      codes_ready = 0;
    endfunction

    function int take_lightest(ref int n);
      int best;
      int id;
      best = 0;
      for (int i = 1; i < n; i++)
        if (weight[node_list[i]] < weight[node_list[best]]) best = i;
      id = node_list[best];
      for (int i = best; i + 1 < n; i++) node_list[i] = node_list[i + 1];
      n--;
      return id;
    endfunction

    function logic [1:0] build_table();
      int n;
      int nxt;
      int a;
      int b;
      int node;
      int depth;
      logic [1:0] st;
      longint w;
      logic [31:0] word;
      st = hcb_pkg::ST_OK;
      n = n_distinct;
      nxt = hcb_pkg::NSYM;
      foreach (word_tab[i]) begin
        word_tab[i] = '0;
        len_tab[i] = 0;
      end
      foreach (parent[i]) begin
        parent[i] = -1;
        branch[i] = 0;
      end
      for (int i = 0; i < n; i++) begin
        weight[first_seen[i]] = sym_cnt[first_seen[i]];
        node_list[i] = first_seen[i];
      end
      while (n > 1) begin
        a = take_lightest(n);
        b = take_lightest(n);
        w = weight[a] + weight[b];
        weight[nxt] = (w > longint'(hcb_pkg::CNT_MAX)) ? longint'(hcb_pkg::CNT_MAX) : w;
        parent[a] = nxt;
        branch[a] = 0;
        parent[b] = nxt;
        branch[b] = 1;
        node_list[n] = nxt;
        n++;
        nxt++;
      end
      if (n_distinct >= 2) begin
        for (int i = 0; i < n_distinct; i++) begin
          node = first_seen[i];
          depth = 0;
          word = '0;
          // The leaf's branch lands in bit 0, so the root's bit ends up on top.
          while (parent[node] >= 0) begin
            if (depth < 32) word[depth] = branch[node][0];
            depth++;
            node = parent[node];
          end
          word_tab[first_seen[i]] = word;
          len_tab[first_seen[i]] = depth;
          if (depth > hcb_pkg::CODE_LIMIT) st = hcb_pkg::ST_TOO_LONG;
        end
      end
      codes_ready = 1;
      return st;
    endfunction

    function void note_command(logic [1:0] mode, logic [7:0] sym);
      hcb_result_t r;
      r = '{hcb_pkg::ST_OK, 1'b0, 32'd0, 6'd0};
      case (mode)
        hcb_pkg::MODE_COUNT: begin
          if (sym_cnt[sym] == 0 && n_distinct < hcb_pkg::NSYM) begin
            first_seen[n_distinct] = sym;
            n_distinct++;
          end
          if (sym_cnt[sym] >= longint'(hcb_pkg::CNT_MAX)) r.status = hcb_pkg::ST_SATURATED;
          else sym_cnt[sym]++;
          codes_ready = 0;
        end
        hcb_pkg::MODE_BUILD: r.status = build_table();
        hcb_pkg::MODE_ENCODE: begin
          if (!codes_ready) r.status = hcb_pkg::ST_NOT_BUILT;
          else if (len_tab[sym] > hcb_pkg::CODE_LIMIT) begin
            r.status = hcb_pkg::ST_TOO_LONG;
            r.present = 1'b1;
          end else if (len_tab[sym] > 0) begin
            r.present = 1'b1;
            r.code_bits = word_tab[sym];
            r.code_length = 6'(len_tab[sym]);
          end
        end
        default: clear_all();
      endcase
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(hcb_result_t got);
      hcb_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with no command outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.present !== want.present)
        report_mismatch($sformatf("present %0d, expected %0d", got.present, want.present));
      if (got.code_bits !== want.code_bits)
        report_mismatch($sformatf("code_bits %h, expected %h", got.code_bits,
                                  want.code_bits));
      if (got.code_length !== want.code_length)
        report_mismatch($sformatf("code_length %0d, expected %0d", got.code_length,
                                  want.code_length));
    endtask
  endclass

  logic clk;
  logic rst_n;
  hcb_in_if  cmd_ch ();
  hcb_out_if res_ch ();

  huffman_code_builder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_ch.sink),
    .out_if (res_ch.source)
  );

  code_table_scoreboard sb;
  int  traffic_phase;     // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  bit  long_hold_req;
  bit  hold_done;
  int  cmds_sent;
  int  big_sets;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function bit sender_idles();
    return (traffic_phase == 1 && $urandom_range(99) < 86) ||
           (traffic_phase == 3 && $urandom_range(99) < 10);
  endfunction

  function bit receiver_stalls();
    return (traffic_phase == 2 && $urandom_range(99) < 86) ||
           (traffic_phase == 3 && $urandom_range(99) < 10);
  endfunction

  task send_cmd(logic [1:0] mode, logic [7:0] sym);
    while (sender_idles()) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.mode      <= mode;
    cmd_ch.data_byte <= sym;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_command(mode, sym);
    cmds_sent++;
    if (cmds_sent % 200 == 0) traffic_phase = (traffic_phase + 1) % 4;
  endtask

  // Receiver side: checks each transfer and chooses ready for the next edge.
  initial begin
    int hold_left;
    hcb_result_t got;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        got.status = res_ch.status;
        got.present = res_ch.present;
        got.code_bits = res_ch.code_bits;
        got.code_length = res_ch.code_length;
        sb.check_result(got);
      end
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= !receiver_stalls();
      end
    end
  end

  initial begin
    #60ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int k;
    int n;
    int base;
    logic [7:0] alpha [hcb_pkg::NSYM];
    sb = new();
    sb.clear_all();
    sb.errors = 0;
    traffic_phase = 0;
    long_hold_req = 0;
    hold_done = 0;
    cmds_sent = 0;
    big_sets = 0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= hcb_pkg::MODE_COUNT;
    cmd_ch.data_byte <= 8'd0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: encode before any build, empty and single-symbol builds,
    // edge bytes, counting after a build, and clear.
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd0);
    send_cmd(hcb_pkg::MODE_BUILD, 8'hA5);
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd255);
    send_cmd(hcb_pkg::MODE_COUNT, 8'd0);
    send_cmd(hcb_pkg::MODE_BUILD, 8'd0);
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd0);
    send_cmd(hcb_pkg::MODE_COUNT, 8'd255);
    send_cmd(hcb_pkg::MODE_COUNT, 8'd0);
    send_cmd(hcb_pkg::MODE_COUNT, 8'd7);
    send_cmd(hcb_pkg::MODE_COUNT, 8'd128);
    send_cmd(hcb_pkg::MODE_COUNT, 8'd128);
    send_cmd(hcb_pkg::MODE_BUILD, 8'd0);
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd0);
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd255);
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd7);
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd128);
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd9);
    send_cmd(hcb_pkg::MODE_COUNT, 8'd7);
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd7);
    send_cmd(hcb_pkg::MODE_CLEAR, 8'hFF);
    send_cmd(hcb_pkg::MODE_ENCODE, 8'd0);

    // Random sessions: usually clear, count over an alphabet, build, then encode; some rounds send one random command.
    while (cmds_sent < 820) begin
      // One long receiver hold-off while the sender keeps offering commands.
      if (traffic_phase == 0 && cmds_sent >= 100 && !hold_done) begin
        long_hold_req = 1;
        hold_done = 1;
      end
      if ($urandom_range(9) == 0) begin
        send_cmd(2'($urandom_range(3)), 8'($urandom_range(255)));
        continue;
      end
      if ($urandom_range(3) != 0) send_cmd(hcb_pkg::MODE_CLEAR, 8'($urandom_range(255)));
      if (big_sets < 2 && cmds_sent < 450 && $urandom_range(40) == 0) begin
        // Full alphabet: every byte value counted, skewed counts.
        big_sets++;
        k = hcb_pkg::NSYM;
        base = $urandom_range(255);
        for (int i = 0; i < hcb_pkg::NSYM; i++) alpha[i] = 8'((base + i) % hcb_pkg::NSYM);
        for (int i = 0; i < hcb_pkg::NSYM; i++) send_cmd(hcb_pkg::MODE_COUNT, alpha[i]);
        for (int i = 0; i < 40; i++)
          send_cmd(hcb_pkg::MODE_COUNT, alpha[$urandom_range(15)]);
      end else begin
        k = $urandom_range(1, 10);
        for (int i = 0; i < k; i++) alpha[i] = 8'($urandom_range(255));
        n = $urandom_range(k, 3 * k + 4);
        for (int i = 0; i < n; i++)
          send_cmd(hcb_pkg::MODE_COUNT, alpha[$urandom_range(k - 1) >> $urandom_range(1)]);
      end
      send_cmd(hcb_pkg::MODE_BUILD, 8'($urandom_range(255)));
      n = $urandom_range(2, 12);
      for (int i = 0; i < n; i++)
        send_cmd(hcb_pkg::MODE_ENCODE, ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                                : alpha[$urandom_range(k - 1)]);
    end
    cmd_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
